[hw/rtl/lstrs_pkg.sv]
// lstrs_pkg: shared types and constants of the lazy segment tree rank/select block
// used by lstrs_ctrl, lstrs_dpath and lazy_segment_tree_rank_select; no dependencies
package lstrs_pkg;

   localparam int NUM_POSITIONS_DEF = 1024;
   localparam int FIELD_POS_W       = 11;
   localparam int DATA_W            = 32;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_PREFIX = 2'd1,
      OP_SELECT = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      CMD_NOP,
      CMD_CLEAR,
      CMD_LOAD,
      CMD_RD_NODE,
      CMD_PUSH,
      CMD_APP_RD,
      CMD_APP_MUL,
      CMD_APP_WR,
      CMD_DOWN_LEFT,
      CMD_DOWN_RIGHT,
      CMD_POP,
      CMD_RD_LEFT,
      CMD_RD_RIGHT,
      CMD_RECALC,
      CMD_STEP,
      CMD_LEAF
   } cmd_type;

   typedef enum logic [1:0] {
      TGT_LEFT,
      TGT_RIGHT,
      TGT_SELF
   } tgt_type;

   typedef enum logic {
      PH_LEFT,
      PH_RIGHT
   } phase_type;

   typedef struct packed {
      cmd_type   cmd;
      tgt_type   tgt;
      logic      push;
      phase_type phase;
   } dp_ctl_type;

   typedef struct packed {
      logic      clear_done;
      op_type    op;
      logic      add_valid;
      logic      prefix_valid;
      logic      is_leaf;
      logic      pend_nz;
      logic      covered;
      logic      want_left;
      logic      want_right;
      logic      key_le_mid;
      logic      stack_empty;
      phase_type phase;
   } dp_stat_type;

endpackage

[hw/rtl/lstrs_dpath.sv]
// lstrs_dpath: tree store, current node frame, return stack and arithmetic
// depends on lstrs_pkg; driven by commands from lstrs_ctrl
module lstrs_dpath #(
   parameter int NUM_POSITIONS = lstrs_pkg::NUM_POSITIONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lstrs_pkg::dp_ctl_type               ctl,
   output lstrs_pkg::dp_stat_type              stat,
   input  logic [$clog2(NUM_POSITIONS+1)-1:0]  positions,
   input  logic [1:0]                          req_operation,
   input  logic [lstrs_pkg::FIELD_POS_W-1:0]   req_range_low,
   input  logic [lstrs_pkg::FIELD_POS_W-1:0]   req_range_high,
   input  logic signed [15:0]                  req_delta,
   input  logic signed [lstrs_pkg::DATA_W-1:0] req_target,
   output logic signed [lstrs_pkg::DATA_W-1:0] answer
);

   localparam int PW    = $clog2(NUM_POSITIONS + 1);
   localparam int XW    = (PW > lstrs_pkg::FIELD_POS_W) ? PW : lstrs_pkg::FIELD_POS_W;
   localparam int DEPTH = 2 * NUM_POSITIONS;
   localparam int NW    = $clog2(DEPTH);
   localparam int SD    = $clog2(NUM_POSITIONS) + 1;
   localparam int SPW   = $clog2(SD + 1);
   localparam int SIW   = $clog2(SD);
   localparam int DW    = lstrs_pkg::DATA_W;

   typedef struct packed {
      logic [DW-1:0] sum;
      logic [DW-1:0] pend;
   } entry_type;

   typedef struct packed {
      logic [NW-1:0]        n;
      logic [PW-1:0]        lo;
      logic [PW-1:0]        hi;
      lstrs_pkg::phase_type phase;
   } frame_type;

   entry_type mem [DEPTH];
   entry_type rdata_ff;
   frame_type stack_ff [SD];

   logic               we;
   logic [NW-1:0]      waddr;
   entry_type          wdata;
   logic               re;
   logic [NW-1:0]      raddr;

   logic [NW-1:0]      clr_ff, clr_in;
   lstrs_pkg::op_type  op_ff, op_in;
   logic [XW-1:0]      a_ff, a_in, b_ff, b_in;
   logic [DW-1:0]      d_ff, d_in;
   logic [DW-1:0]      key_ff, key_in;
   logic [DW-1:0]      acc_ff, acc_in;
   logic [DW-1:0]      ans_ff, ans_in;
   logic [NW-1:0]      n_ff, n_in;
   logic [PW-1:0]      lo_ff, lo_in, hi_ff, hi_in;
   lstrs_pkg::phase_type phase_ff, phase_in;
   logic [SPW-1:0]     sp_ff, sp_in;
   logic [DW-1:0]      pend_n_ff, pend_n_in, sum_n_ff, sum_n_in;
   logic [DW-1:0]      app_sum_ff, app_sum_in, app_pend_ff, app_pend_in;
   logic [DW-1:0]      prod_ff, prod_in, tmp_ff, tmp_in;

   logic               do_push;
   frame_type          push_frame;
   logic [SIW-1:0]     top_idx;

   logic [PW:0]        lohi;
   logic [PW-1:0]      mid, len, len_l, len_r, app_len;
   logic [NW-1:0]      left, right, tgt_addr;
   logic [DW-1:0]      app_val;
   logic [XW-1:0]      pos_x, low_x, targ_clip_x;
   logic [DW-1:0]      pos_d;

   // node geometry
   assign lohi  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid   = lohi[PW:1];
   assign len   = hi_ff - lo_ff + PW'(1);
   assign len_l = mid - lo_ff + PW'(1);
   assign len_r = hi_ff - mid;
   assign left  = n_ff + NW'(1);
   assign right = n_ff + NW'({len_l, 1'b0});

   always_comb begin
      case (ctl.tgt)
         lstrs_pkg::TGT_LEFT: begin
            tgt_addr = left;
            app_len  = len_l;
            app_val  = pend_n_ff;
         end
         lstrs_pkg::TGT_RIGHT: begin
            tgt_addr = right;
            app_len  = len_r;
            app_val  = pend_n_ff;
         end
         default: begin
            tgt_addr = n_ff;
            app_len  = len;
            app_val  = d_ff;
         end
      endcase
   end

   assign pos_x       = XW'(positions);
   assign low_x       = XW'(req_range_low);
   assign targ_clip_x = XW'(req_range_high);
   assign pos_d       = DW'(positions);
   assign top_idx     = SIW'(sp_ff - SPW'(1));

   always_comb begin
      we          = 1'b0;
      waddr       = n_ff;
      wdata       = '0;
      re          = 1'b0;
      raddr       = n_ff;
      clr_in      = clr_ff;
      op_in       = op_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      d_in        = d_ff;
      key_in      = key_ff;
      acc_in      = acc_ff;
      ans_in      = ans_ff;
      n_in        = n_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      phase_in    = phase_ff;
      sp_in       = sp_ff;
      pend_n_in   = pend_n_ff;
      sum_n_in    = sum_n_ff;
      app_sum_in  = app_sum_ff;
      app_pend_in = app_pend_ff;
      prod_in     = prod_ff;
      tmp_in      = tmp_ff;
      do_push     = 1'b0;
      push_frame  = '{n: n_ff, lo: lo_ff, hi: hi_ff, phase: ctl.phase};
      case (ctl.cmd)
         lstrs_pkg::CMD_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff;
            clr_in = clr_ff + NW'(1);
         end
         lstrs_pkg::CMD_LOAD: begin
            op_in  = lstrs_pkg::op_type'(req_operation);
            a_in   = (low_x == '0) ? XW'(1) : low_x;
            b_in   = (targ_clip_x > pos_x) ? pos_x : targ_clip_x;
            d_in   = DW'(req_delta);
            key_in = req_target;
            if (lstrs_pkg::op_type'(req_operation) == lstrs_pkg::OP_PREFIX &&
                  $signed(req_target) > $signed(pos_d)) begin
               key_in = pos_d;
            end
            acc_in = '0;
            ans_in = '0;
            n_in   = '0;
            lo_in  = PW'(1);
            hi_in  = positions;
            sp_in  = '0;
         end
         lstrs_pkg::CMD_RD_NODE: begin
            re = 1'b1;
         end
         lstrs_pkg::CMD_PUSH: begin
            pend_n_in = rdata_ff.pend;
            sum_n_in  = rdata_ff.sum;
            we        = 1'b1;
            wdata     = '{sum: rdata_ff.sum, pend: '0};
         end
         lstrs_pkg::CMD_APP_RD: begin
            re    = 1'b1;
            raddr = tgt_addr;
         end
         lstrs_pkg::CMD_APP_MUL: begin
            app_sum_in  = rdata_ff.sum;
            app_pend_in = rdata_ff.pend;
            prod_in     = app_val * DW'(app_len);
         end
         lstrs_pkg::CMD_APP_WR: begin
            we    = 1'b1;
            waddr = tgt_addr;
            wdata = '{sum: app_sum_ff + prod_ff, pend: app_pend_ff + app_val};
         end
         lstrs_pkg::CMD_DOWN_LEFT: begin
            do_push = ctl.push;
            n_in    = left;
            hi_in   = mid;
         end
         lstrs_pkg::CMD_DOWN_RIGHT: begin
            do_push = ctl.push;
            n_in    = right;
            lo_in   = mid + PW'(1);
         end
         lstrs_pkg::CMD_POP: begin
            n_in     = stack_ff[top_idx].n;
            lo_in    = stack_ff[top_idx].lo;
            hi_in    = stack_ff[top_idx].hi;
            phase_in = stack_ff[top_idx].phase;
            sp_in    = sp_ff - SPW'(1);
         end
         lstrs_pkg::CMD_RD_LEFT: begin
            re    = 1'b1;
            raddr = left;
         end
         lstrs_pkg::CMD_RD_RIGHT: begin
            tmp_in = rdata_ff.sum;
            re     = 1'b1;
            raddr  = right;
         end
         lstrs_pkg::CMD_RECALC: begin
            we    = 1'b1;
            wdata = '{sum: tmp_ff + rdata_ff.sum, pend: '0};
         end
         lstrs_pkg::CMD_STEP: begin
            // rdata holds the left child after its push-down
            if (op_ff == lstrs_pkg::OP_PREFIX) begin
               acc_in = acc_ff + rdata_ff.sum;
               n_in   = right;
               lo_in  = mid + PW'(1);
            end else if ($signed(key_ff) <= $signed(rdata_ff.sum)) begin
               n_in  = left;
               hi_in = mid;
            end else begin
               key_in = key_ff - rdata_ff.sum;
               n_in   = right;
               lo_in  = mid + PW'(1);
            end
         end
         lstrs_pkg::CMD_LEAF: begin
            ans_in = (op_ff == lstrs_pkg::OP_PREFIX) ? acc_ff + sum_n_ff : DW'(lo_ff);
         end
         default: begin
         end
      endcase
      if (do_push) begin
         sp_in = sp_ff + SPW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         stack_ff[sp_ff[SIW-1:0]] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         sp_ff  <= '0;
      end else begin
         clr_ff <= clr_in;
         sp_ff  <= sp_in;
      end
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      d_ff        <= d_in;
      key_ff      <= key_in;
      acc_ff      <= acc_in;
      ans_ff      <= ans_in;
      n_ff        <= n_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      phase_ff    <= phase_in;
      pend_n_ff   <= pend_n_in;
      sum_n_ff    <= sum_n_in;
      app_sum_ff  <= app_sum_in;
      app_pend_ff <= app_pend_in;
      prod_ff     <= prod_in;
      tmp_ff      <= tmp_in;
   end

   assign answer = ans_ff;

   always_comb begin
      stat.clear_done   = (clr_ff == NW'(DEPTH - 1));
      stat.op           = op_ff;
      stat.add_valid    = (a_ff <= b_ff);
      stat.prefix_valid = !key_ff[DW-1] && (key_ff != '0);
      stat.is_leaf      = (lo_ff == hi_ff);
      stat.pend_nz      = (rdata_ff.pend != '0);
      stat.covered      = (a_ff <= XW'(lo_ff)) && (XW'(hi_ff) <= b_ff);
      stat.want_left    = (a_ff <= XW'(mid));
      stat.want_right   = (b_ff > XW'(mid));
      stat.key_le_mid   = (key_ff[PW-1:0] <= mid);
      stat.stack_empty  = (sp_ff == '0);
      stat.phase        = phase_ff;
   end

endmodule

[hw/rtl/lstrs_ctrl.sv]
// lstrs_ctrl: sequencer for clearing, push-down, descent, unwinding and result
// depends on lstrs_pkg; commands lstrs_dpath
module lstrs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_valid,
   output lstrs_pkg::dp_ctl_type  ctl,
   input  lstrs_pkg::dp_stat_type stat
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_RD_NODE,
      ST_PUSH,
      ST_APP_RD,
      ST_APP_MUL,
      ST_APP_WR,
      ST_DECIDE,
      ST_STEP,
      ST_RETURN,
      ST_RESUME,
      ST_RC_R,
      ST_RC_WR,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   lstrs_pkg::tgt_type tgt_ff, tgt_in;
   logic               busy_ff, rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      tgt_in    = tgt_ff;
      ctl.cmd   = lstrs_pkg::CMD_NOP;
      ctl.tgt   = tgt_ff;
      ctl.push  = 1'b0;
      ctl.phase = lstrs_pkg::PH_LEFT;
      case (state_ff)
         ST_CLEAR: begin
            ctl.cmd = lstrs_pkg::CMD_CLEAR;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               ctl.cmd  = lstrs_pkg::CMD_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if ((stat.op == lstrs_pkg::OP_ADD && stat.add_valid) ||
                  (stat.op == lstrs_pkg::OP_PREFIX && stat.prefix_valid) ||
                  stat.op == lstrs_pkg::OP_SELECT) begin
               state_in = ST_RD_NODE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RD_NODE: begin
            ctl.cmd  = lstrs_pkg::CMD_RD_NODE;
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            ctl.cmd = lstrs_pkg::CMD_PUSH;
            if (!stat.is_leaf && stat.pend_nz) begin
               tgt_in   = lstrs_pkg::TGT_LEFT;
               state_in = ST_APP_RD;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_APP_RD: begin
            ctl.cmd  = lstrs_pkg::CMD_APP_RD;
            state_in = ST_APP_MUL;
         end
         ST_APP_MUL: begin
            ctl.cmd  = lstrs_pkg::CMD_APP_MUL;
            state_in = ST_APP_WR;
         end
         ST_APP_WR: begin
            ctl.cmd = lstrs_pkg::CMD_APP_WR;
            case (tgt_ff)
               lstrs_pkg::TGT_LEFT: begin
                  tgt_in   = lstrs_pkg::TGT_RIGHT;
                  state_in = ST_APP_RD;
               end
               lstrs_pkg::TGT_RIGHT: begin
                  state_in = ST_DECIDE;
               end
               default: begin
                  state_in = ST_RETURN;
               end
            endcase
         end
         ST_DECIDE: begin
            if (stat.op == lstrs_pkg::OP_ADD) begin
               if (stat.covered) begin
                  tgt_in   = lstrs_pkg::TGT_SELF;
                  state_in = ST_APP_RD;
               end else if (stat.want_left) begin
                  ctl.cmd   = lstrs_pkg::CMD_DOWN_LEFT;
                  ctl.push  = 1'b1;
                  ctl.phase = lstrs_pkg::PH_LEFT;
                  state_in  = ST_RD_NODE;
               end else begin
                  ctl.cmd   = lstrs_pkg::CMD_DOWN_RIGHT;
                  ctl.push  = 1'b1;
                  ctl.phase = lstrs_pkg::PH_RIGHT;
                  state_in  = ST_RD_NODE;
               end
            end else if (stat.is_leaf) begin
               ctl.cmd  = lstrs_pkg::CMD_LEAF;
               state_in = ST_DONE;
            end else if (stat.op == lstrs_pkg::OP_PREFIX && stat.key_le_mid) begin
               ctl.cmd  = lstrs_pkg::CMD_DOWN_LEFT;
               state_in = ST_RD_NODE;
            end else begin
               ctl.cmd  = lstrs_pkg::CMD_RD_LEFT;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            ctl.cmd  = lstrs_pkg::CMD_STEP;
            state_in = ST_RD_NODE;
         end
         ST_RETURN: begin
            if (stat.stack_empty) begin
               state_in = ST_DONE;
            end else begin
               ctl.cmd  = lstrs_pkg::CMD_POP;
               state_in = ST_RESUME;
            end
         end
         ST_RESUME: begin
            if (stat.phase == lstrs_pkg::PH_LEFT && stat.want_right) begin
               ctl.cmd   = lstrs_pkg::CMD_DOWN_RIGHT;
               ctl.push  = 1'b1;
               ctl.phase = lstrs_pkg::PH_RIGHT;
               state_in  = ST_RD_NODE;
            end else begin
               ctl.cmd  = lstrs_pkg::CMD_RD_LEFT;
               state_in = ST_RC_R;
            end
         end
         ST_RC_R: begin
            ctl.cmd  = lstrs_pkg::CMD_RD_RIGHT;
            state_in = ST_RC_WR;
         end
         ST_RC_WR: begin
            ctl.cmd  = lstrs_pkg::CMD_RECALC;
            state_in = ST_RETURN;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         tgt_ff       <= lstrs_pkg::TGT_LEFT;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tgt_ff       <= tgt_in;
         busy_ff      <= (state_in != ST_IDLE);
         rsp_valid_ff <= (state_ff == ST_DONE);
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/lazy_segment_tree_rank_select.sv]
// lazy_segment_tree_rank_select: segment tree with lazy range add, prefix sum and k-th select
// depends on lstrs_pkg, lstrs_ctrl and lstrs_dpath
//
// A request is taken when start is high and busy is low; its single result appears on
// rsp_answer with rsp_valid high for exactly one cycle and the receiver cannot stall it.
// After reset the tree store (2*NUM_POSITIONS entries) is swept to zero one entry a
// cycle, so busy stays high until the sweep is done. Each node visit is a serialized
// read-modify-write of the tree memory: the node is read and its pending add cleared;
// an inner node's nonzero pending add is pushed to the left and then the right child
// (read, multiply by the child's length, write back); a prefix sum that goes right and
// a select read the left child's sum before stepping down. A range add visits up to
// two paths and rewrites each node on them on the way back.
// csr_write_data sets the highest covered position (0 acts as 1, values above
// NUM_POSITIONS clamp); write it only while the block is idle.
module lazy_segment_tree_rank_select #(
   parameter int NUM_POSITIONS = lstrs_pkg::NUM_POSITIONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_operation,
   input  logic [lstrs_pkg::FIELD_POS_W-1:0]   req_range_low,
   input  logic [lstrs_pkg::FIELD_POS_W-1:0]   req_range_high,
   input  logic signed [15:0]                  req_delta,
   input  logic signed [lstrs_pkg::DATA_W-1:0] req_target,
   // result channel
   output logic                                rsp_valid,
   output logic signed [lstrs_pkg::DATA_W-1:0] rsp_answer,
   // configuration
   input  logic                                csr_write_enable,
   input  logic [lstrs_pkg::FIELD_POS_W-1:0]   csr_write_data
);

   localparam int PW = $clog2(NUM_POSITIONS + 1);
   localparam int XW = (PW > lstrs_pkg::FIELD_POS_W) ? PW : lstrs_pkg::FIELD_POS_W;

   // positions in use register
   logic [lstrs_pkg::FIELD_POS_W-1:0] csr_pos_ff, csr_pos_in;
   logic [XW-1:0]                     pos_x;
   logic [XW-1:0]                     pos_clamp;

   lstrs_pkg::dp_ctl_type  ctl;
   lstrs_pkg::dp_stat_type stat;

   assign csr_pos_in = csr_write_enable ? csr_write_data : csr_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_pos_ff <= lstrs_pkg::FIELD_POS_W'(1024);
      end else begin
         csr_pos_ff <= csr_pos_in;
      end
   end

   // clamp into 1..NUM_POSITIONS
   assign pos_x = XW'(csr_pos_ff);
   always_comb begin
      if (pos_x == '0) begin
         pos_clamp = XW'(1);
      end else if (pos_x > XW'(NUM_POSITIONS)) begin
         pos_clamp = XW'(NUM_POSITIONS);
      end else begin
         pos_clamp = pos_x;
      end
   end

   // sequencer
   lstrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl),
      .stat      (stat)
   );

   // tree store and arithmetic
   lstrs_dpath #(
      .NUM_POSITIONS (NUM_POSITIONS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .stat           (stat),
      .positions      (pos_clamp[PW-1:0]),
      .req_operation  (req_operation),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .req_delta      (req_delta),
      .req_target     (req_target),
      .answer         (rsp_answer)
   );

   // a result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a result only ends a request that was being worked on
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a request in flight");

   // a taken request makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   // a result is never shown right after a request is taken
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result shown right after a request was taken");

endmodule
